// File: src/lqrpl_pkg.sv
// ----------------------------------------------------------------------------
// LQR position loop package
// Shared widths, fixed-point constants, register indexes and the divider
// status type.
// ----------------------------------------------------------------------------
package lqrpl_pkg;

  localparam int unsigned OPW   = 33;
  localparam int unsigned PRODW = 2 * OPW;
  localparam int unsigned ACCW  = 64;
  localparam int unsigned INTW  = 48;
  localparam int unsigned GAINW = 32;

  localparam logic signed [OPW-1:0] RAD_Q32 = 33'sd6588397;
  localparam logic signed [OPW-1:0] INC_Q32 = 33'sd13177;
  localparam logic signed [OPW-1:0] MA_SCALE = 33'sd1000;

  localparam logic signed [GAINW-1:0] VEL_GAIN_RST = 32'sd6577;
  localparam logic signed [GAINW-1:0] POS_GAIN_RST = 32'sd887771;
  localparam logic signed [GAINW-1:0] INT_GAIN_RST = 32'sd33158885;

  localparam logic [1:0] REG_VEL_GAIN = 2'd0;
  localparam logic [1:0] REG_POS_GAIN = 2'd1;
  localparam logic [1:0] REG_INT_GAIN = 2'd2;

  localparam int unsigned DIVW       = 64;
  localparam int unsigned REMW       = 7;
  localparam logic [REMW:0] AW_DIVISOR = 8'd125;

  localparam int unsigned DIGW        = 16;
  localparam int unsigned DIVX        = REMW + DIGW;
  localparam int unsigned RECIPW      = 24;
  localparam int unsigned PARTW       = DIVX + RECIPW;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIPW-1:0] AW_RECIP = 24'd8589935;

  typedef struct packed {
    logic busy;
    logic done;
    logic neg;
  } div_status_t;

endpackage

// File: src/lqrpl_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 by 33 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module lqrpl_mul (
  input  logic                                clk,
  input  logic signed [lqrpl_pkg::OPW-1:0]    op_a,
  input  logic signed [lqrpl_pkg::OPW-1:0]    op_b,
  output logic signed [lqrpl_pkg::PRODW-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

// File: src/lqrpl_div.sv
// ----------------------------------------------------------------------------
// Anti-windup divider
// Forms trunc(4 * excess / 125) as a magnitude and a sign, sixteen quotient
// bits per cycle by reciprocal multiplication against the constant divisor.
// ----------------------------------------------------------------------------
module lqrpl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lqrpl_pkg::ACCW-1:0]   excess,
  output logic        [lqrpl_pkg::DIVW-1:0]   quotient,
  output lqrpl_pkg::div_status_t              status
);

  logic [lqrpl_pkg::DIVW-1:0]  work_r, work_nxt;
  logic [lqrpl_pkg::REMW-1:0]  rem_r, rem_nxt;
  logic [1:0]                  cnt_r;
  logic                        busy_r, done_r, neg_r;
  logic [lqrpl_pkg::ACCW-1:0]  abs_excess;
  logic [lqrpl_pkg::DIVX-1:0]  part;
  logic [lqrpl_pkg::PARTW-1:0] part_prod;
  logic [lqrpl_pkg::DIGW-1:0]  digit;
  logic [lqrpl_pkg::DIVX-1:0]  part_rem;

  // The partial dividend is always below 125 * 2^16, for which the scaled
  // reciprocal gives the exact quotient digit.
  assign part      = {rem_r, work_r[lqrpl_pkg::DIVW-1 -: lqrpl_pkg::DIGW]};
  assign part_prod = {{lqrpl_pkg::RECIPW{1'b0}}, part} *
                     {{lqrpl_pkg::DIVX{1'b0}}, lqrpl_pkg::AW_RECIP};
  assign digit     = part_prod[lqrpl_pkg::RECIP_SHIFT +: lqrpl_pkg::DIGW];
  assign part_rem  = part - ({{lqrpl_pkg::REMW{1'b0}}, digit} *
                     {{(lqrpl_pkg::DIVX - lqrpl_pkg::REMW - 1){1'b0}},
                      lqrpl_pkg::AW_DIVISOR});
  assign rem_nxt   = part_rem[lqrpl_pkg::REMW-1:0];
  assign work_nxt  = {work_r[lqrpl_pkg::DIVW-lqrpl_pkg::DIGW-1:0], digit};

  assign abs_excess = excess[lqrpl_pkg::ACCW-1] ? -excess : excess;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= excess[lqrpl_pkg::ACCW-1];
      work_r <= {abs_excess[lqrpl_pkg::ACCW-3:0], 2'b00};
      rem_r  <= '0;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient    = work_r;
  assign status.busy = busy_r;
  assign status.done = done_r;
  assign status.neg  = neg_r;

endmodule

// File: src/lqr_position_loop_antiwindup_core.sv
// ----------------------------------------------------------------------------
// LQR position loop with integral action and anti-windup
// Computes the clipped current demand of a position servo once per tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one control tick per transfer: target position,
//   measured position and measured velocity in encoder counts. The output
//   stream returns one transfer per tick with the current demand in mA and
//   the saturation flag in tuser.
//   All products but those of the anti-windup divider go through one shared
//   33 by 33 bit multiplier under a sequencer. When the demand is clipped,
//   the anti-windup division by 125 runs sixteen bits a cycle by reciprocal
//   multiplication, and the sequencer waits for it before it outputs the
//   result. in_tready is high only while the sequencer idles. The output
//   register lets a new tick be accepted while a result still waits; if the
//   receiver stalls, the next result holds in the sequencer until the output
//   register is free.
//   The user must write the gain registers through the cfg port while idle;
//   the block does not enforce it. Reset clears the integral, restores the
//   default gains and empties the output register.
// ----------------------------------------------------------------------------
module lqr_position_loop_antiwindup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_position [31:0], measured_position [63:32], measured_velocity [87:64]
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_current_ma [10:0], zero fill [15:11]
  output logic [15:0] out_tdata,
  // saturated [0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_INT, S_G0, S_G1, S_VEL, S_POS, S_ILO, S_IHI,
    S_ITERM, S_SUM, S_CLIP, S_MA, S_RND, S_AW
  } state_t;

  localparam logic signed [63:0] I48_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] I48_MIN = -64'sd140737488355328;
  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;
  localparam logic [39:0]        RND_HALF = 40'd134217728;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x > I48_MAX) begin
      return I48_MAX[47:0];
    end else if (x < I48_MIN) begin
      return I48_MIN[47:0];
    end
    return x[47:0];
  endfunction

  state_t state_r;

  logic signed [31:0] vel_gain_r, pos_gain_r, int_gain_r;
  logic signed [47:0] int_r;
  logic signed [32:0] d_r;
  logic signed [31:0] pos_r;
  logic signed [23:0] vel_r;
  logic signed [30:0] g0_r, g1_r;
  logic signed [63:0] acc_r, u_r, excess_r;
  logic signed [47:0] t_r;
  logic signed [55:0] it_r;
  logic        [28:0] mag_r;
  logic               neg_r, sat_r;
  logic signed [10:0] ma_r;
  logic               out_tvalid_r;
  logic        [10:0] out_ma_r;
  logic               out_sat_r;

  logic signed [lqrpl_pkg::OPW-1:0]   op_a, op_b;
  logic signed [lqrpl_pkg::PRODW-1:0] prod_r;
  logic                               div_start;
  logic        [lqrpl_pkg::DIVW-1:0]  div_q;
  lqrpl_pkg::div_status_t             div_sts;

  logic signed [63:0] int_ext, int_sum, iterm_sum, aw_sum;
  logic        [39:0] rnd;
  logic               out_free;
  logic               aw_fire;

  lqrpl_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  lqrpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .excess   (excess_r),
    .quotient (div_q),
    .status   (div_sts)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_INT: begin
        op_a = d_r;
        op_b = lqrpl_pkg::INC_Q32;
      end
      S_G0: begin
        op_a = 33'(vel_gain_r);
        op_b = lqrpl_pkg::RAD_Q32;
      end
      S_G1: begin
        op_a = 33'(pos_gain_r);
        op_b = lqrpl_pkg::RAD_Q32;
      end
      S_VEL: begin
        op_a = 33'(g0_r);
        op_b = 33'(vel_r);
      end
      S_POS: begin
        op_a = 33'(g1_r);
        op_b = 33'(pos_r);
      end
      S_ILO: begin
        op_a = 33'(int_gain_r);
        op_b = $signed({17'd0, int_r[15:0]});
      end
      S_IHI: begin
        op_a = 33'(int_gain_r);
        op_b = 33'($signed(int_r[47:16]));
      end
      S_MA: begin
        op_a = $signed({4'd0, mag_r});
        op_b = lqrpl_pkg::MA_SCALE;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign div_start = (state_r == S_MA) && sat_r;
  assign int_ext   = 64'(int_r);
  assign int_sum   = int_ext + prod_r[63:0];
  assign iterm_sum = prod_r[63:0] + 64'(t_r);
  assign aw_sum    = div_sts.neg ? int_ext + $signed(div_q) : int_ext - $signed(div_q);
  assign rnd       = prod_r[39:0] + RND_HALF;
  assign out_free  = !out_tvalid_r || out_tready;
  assign aw_fire   = (state_r == S_AW) && (!sat_r || div_sts.done) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      int_r        <= '0;
      vel_gain_r   <= lqrpl_pkg::VEL_GAIN_RST;
      pos_gain_r   <= lqrpl_pkg::POS_GAIN_RST;
      int_gain_r   <= lqrpl_pkg::INT_GAIN_RST;
    end else begin
      if (aw_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          lqrpl_pkg::REG_VEL_GAIN: vel_gain_r <= cfg_wdata;
          lqrpl_pkg::REG_POS_GAIN: pos_gain_r <= cfg_wdata;
          lqrpl_pkg::REG_INT_GAIN: int_gain_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            d_r     <= 33'($signed(in_tdata[31:0])) - 33'($signed(in_tdata[63:32]));
            pos_r   <= in_tdata[63:32];
            vel_r   <= in_tdata[87:64];
            state_r <= S_INT;
          end
        end
        S_INT: state_r <= S_G0;
        S_G0: begin
          int_r   <= sat48(int_sum);
          state_r <= S_G1;
        end
        S_G1: begin
          g0_r    <= prod_r[54:24];
          state_r <= S_VEL;
        end
        S_VEL: begin
          g1_r    <= prod_r[54:24];
          state_r <= S_POS;
        end
        S_POS: begin
          acc_r   <= -prod_r[63:0];
          state_r <= S_ILO;
        end
        S_ILO: begin
          acc_r   <= acc_r - prod_r[63:0];
          state_r <= S_IHI;
        end
        S_IHI: begin
          t_r     <= prod_r[63:16];
          state_r <= S_ITERM;
        end
        S_ITERM: begin
          it_r    <= iterm_sum[63:8];
          state_r <= S_SUM;
        end
        S_SUM: begin
          u_r     <= acc_r + 64'(it_r);
          state_r <= S_CLIP;
        end
        S_CLIP: begin
          if (u_r > ONE_Q28) begin
            sat_r    <= 1'b1;
            neg_r    <= 1'b0;
            mag_r    <= ONE_Q28[28:0];
            excess_r <= u_r - ONE_Q28;
          end else if (u_r < -ONE_Q28) begin
            sat_r    <= 1'b1;
            neg_r    <= 1'b1;
            mag_r    <= ONE_Q28[28:0];
            excess_r <= u_r + ONE_Q28;
          end else begin
            sat_r    <= 1'b0;
            neg_r    <= u_r[63];
            mag_r    <= u_r[63] ? -u_r[28:0] : u_r[28:0];
            excess_r <= '0;
          end
          state_r <= S_MA;
        end
        S_MA: state_r <= S_RND;
        S_RND: begin
          ma_r    <= neg_r ? -$signed(rnd[38:28]) : $signed(rnd[38:28]);
          state_r <= S_AW;
        end
        S_AW: begin
          if (aw_fire) begin
            if (sat_r) begin
              int_r <= sat48(aw_sum);
            end
            out_ma_r  <= ma_r;
            out_sat_r <= sat_r;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_ma_r};
  assign out_tuser  = out_sat_r;

  a_sat_full_scale : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      ($signed(out_tdata[10:0]) == 11'sd1000 || $signed(out_tdata[10:0]) == -11'sd1000))
    else $error("saturated result is not at full scale");

  a_ma_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[10:0]) <= 11'sd1000 && $signed(out_tdata[10:0]) >= -11'sd1000))
    else $error("current demand outside the unit range");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a tick is in progress");

  a_div_only_on_sat : assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> sat_r)
    else $error("anti-windup division running without saturation");

endmodule

// File: verif/tb_lqr_position_loop_antiwindup_core.sv
// ----------------------------------------------------------------------------
// Testbench for the LQR position loop with anti-windup
// Drives control ticks into the input stream under random gaps and receiver
// stalls. A fixed-point predictor of the servo, with its own gains and
// integral, forms the expected current demand and saturation flag. An
// always block compares each output transfer with that prediction. The run
// covers default, scaled, random, small and extreme gains, integral
// clamping, and writes to the unused register index.
// ----------------------------------------------------------------------------
module tb_lqr_position_loop_antiwindup_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 60;

  localparam logic signed [31:0] CNT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;
  localparam logic signed [23:0] VEL_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] VEL_MIN = 24'sh80_0000;

  localparam longint UNIT_Q28 = 64'sd1 <<< 28;
  localparam longint INTEG_MAX = (64'sd1 <<< 47) - 1;
  localparam longint INTEG_MIN = -(64'sd1 <<< 47);

  typedef struct packed {
    logic signed [10:0] ma;
    logic               sat;
  } demand_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  longint  gain_vel = lqrpl_pkg::VEL_GAIN_RST;
  longint  gain_pos = lqrpl_pkg::POS_GAIN_RST;
  longint  gain_int = lqrpl_pkg::INT_GAIN_RST;
  longint  integ_q32 = 0;
  demand_t demand_q[$];
  int      mismatch_cnt = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  bit      idle_en = 1'b1;

  lqr_position_loop_antiwindup_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint clip48(input longint x);
    if (x > INTEG_MAX) return INTEG_MAX;
    if (x < INTEG_MIN) return INTEG_MIN;
    return x;
  endfunction

  function automatic demand_t predict_demand(input logic signed [31:0] tgt,
                                             input logic signed [31:0] pos,
                                             input logic signed [23:0] vel);
    longint t, p, v, g_vel, g_pos, hi, lo, iterm, u, usat, excess, aw, mag, ma;
    demand_t r;
    t = tgt;
    p = pos;
    v = vel;
    integ_q32 = clip48(integ_q32 + (t - p) * lqrpl_pkg::INC_Q32);
    g_vel = (gain_vel * lqrpl_pkg::RAD_Q32) >>> 24;
    g_pos = (gain_pos * lqrpl_pkg::RAD_Q32) >>> 24;
    hi = integ_q32 >>> 16;
    lo = integ_q32 & 64'hFFFF;
    iterm = (gain_int * hi + ((gain_int * lo) >>> 16)) >>> 8;
    u = -(g_vel * v) - (g_pos * p) + iterm;
    usat = u;
    if (usat > UNIT_Q28) begin
      usat = UNIT_Q28;
    end else if (usat < -UNIT_Q28) begin
      usat = -UNIT_Q28;
    end
    excess = u - usat;
    aw = (excess / 125) * 4 + ((excess % 125) * 4) / 125;
    integ_q32 = clip48(integ_q32 - aw);
    mag = (usat < 0) ? -usat : usat;
    ma = (mag * 1000 + (64'sd1 <<< 27)) >>> 28;
    if (usat < 0) begin
      ma = -ma;
    end
    r.ma = ma[10:0];
    r.sat = (usat != u);
    return r;
  endfunction

  function automatic logic [31:0] scale_gain(input int nominal);
    int span;
    span = 2 * nominal;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Leaves in_tvalid high after the transfer so that back-to-back ticks
  // need no second assignment in the same step.
  task automatic send_tick(input logic signed [31:0] tgt, input logic signed [31:0] pos,
                           input logic signed [23:0] vel);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        while (!in_tready) @(posedge clk);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vel, pos, tgt};
    do @(posedge clk); while (!in_tready);
    demand_q.push_back(predict_demand(tgt, pos, vel));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (demand_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      lqrpl_pkg::REG_VEL_GAIN: gain_vel = $signed(val);
      lqrpl_pkg::REG_POS_GAIN: gain_pos = $signed(val);
      lqrpl_pkg::REG_INT_GAIN: gain_int = $signed(val);
      default: ;
    endcase
  endtask

  task automatic program_gains(input logic [31:0] kv, input logic [31:0] kp,
                               input logic [31:0] ki);
    write_reg(lqrpl_pkg::REG_VEL_GAIN, kv);
    write_reg(lqrpl_pkg::REG_POS_GAIN, kp);
    write_reg(lqrpl_pkg::REG_INT_GAIN, ki);
  endtask

  task automatic send_random_tick();
    logic signed [31:0] tgt, pos;
    logic signed [23:0] vel;
    int unsigned pick;
    int p;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      p = int'($urandom_range(0, 600)) - 300;
      pos = p;
      tgt = p + int'($urandom_range(0, 120)) - 60;
      vel = 24'(int'($urandom_range(0, 60000)) - 30000);
    end else if (pick < 65) begin
      pos = int'($urandom_range(0, 8192)) - 4096;
      tgt = int'($urandom_range(0, 8192)) - 4096;
      vel = 24'(int'($urandom_range(0, 600000)) - 300000);
    end else if (pick < 90) begin
      tgt = $urandom;
      pos = $urandom;
      vel = 24'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: tgt = CNT_MAX;
        1: tgt = CNT_MIN;
        2: tgt = 0;
        3: tgt = -1;
        default: tgt = 1;
      endcase
      case ($urandom_range(0, 4))
        0: pos = CNT_MAX;
        1: pos = CNT_MIN;
        2: pos = 0;
        3: pos = -1;
        default: pos = 1;
      endcase
      case ($urandom_range(0, 4))
        0: vel = VEL_MAX;
        1: vel = VEL_MIN;
        2: vel = 0;
        3: vel = -1;
        default: vel = 1;
      endcase
    end
    send_tick(tgt, pos, vel);
  endtask

  task automatic test_default_gains();
    send_tick(0, 0, 0);
    send_tick(0, 100, 0);
    send_tick(0, 0, 1000);
    send_tick(CNT_MAX, 0, 0);
    send_tick(CNT_MIN, 0, 0);
    send_tick(0, CNT_MAX, 0);
    send_tick(0, CNT_MIN, 0);
    send_tick(0, 0, VEL_MAX);
    send_tick(0, 0, VEL_MIN);
  endtask

  // With only a tiny integral gain the demand stays inside the unit range,
  // so the clamped integral shows up directly in the current.
  task automatic test_integral_clamp();
    program_gains(0, 0, 1);
    repeat (4) send_tick(CNT_MAX, CNT_MIN, 0);
    repeat (5) send_tick(CNT_MIN, CNT_MAX, 0);
  endtask

  task automatic test_extreme_gains();
    program_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_tick(CNT_MAX, CNT_MIN, VEL_MAX);
    send_tick(CNT_MIN, CNT_MAX, VEL_MIN);
    send_tick(CNT_MAX, CNT_MAX, VEL_MAX);
    program_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(CNT_MAX, CNT_MIN, VEL_MIN);
    send_tick(CNT_MIN, CNT_MAX, VEL_MAX);
    send_tick(CNT_MIN, CNT_MIN, VEL_MIN);
  endtask

  task automatic test_random_traffic();
    int unsigned pause_at;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0, 6: program_gains(lqrpl_pkg::VEL_GAIN_RST, lqrpl_pkg::POS_GAIN_RST,
                            lqrpl_pkg::INT_GAIN_RST);
        1, 4: program_gains(scale_gain(lqrpl_pkg::VEL_GAIN_RST),
                            scale_gain(lqrpl_pkg::POS_GAIN_RST),
                            scale_gain(lqrpl_pkg::INT_GAIN_RST));
        2, 5: program_gains($urandom, $urandom, $urandom);
        default: program_gains(32'($signed(16'($urandom))), 32'($signed(16'($urandom))),
                               32'($signed(16'($urandom))));
      endcase
      if (ph == 6) begin
        idle_en = 1'b0;
      end
      pause_at = $urandom_range(20, 180);
      for (int n = 0; n < 205; n++) begin
        if (n == pause_at) begin
          wait_drained();
        end
        send_random_tick();
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_demand
    demand_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (demand_q.size() == 0) begin
        $error("unexpected transfer: drive_current_ma %0d saturated %0d",
               $signed(out_tdata[10:0]), out_tuser[0]);
        mismatch_cnt++;
      end else begin
        want = demand_q.pop_front();
        if (out_tdata[10:0] !== want.ma) begin
          $error("drive_current_ma: expected %0d, actual %0d", want.ma,
                 $signed(out_tdata[10:0]));
          mismatch_cnt++;
        end
        if (out_tuser[0] !== want.sat) begin
          $error("saturated: expected %0d, actual %0d", want.sat, out_tuser[0]);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_gains();
    test_integral_clamp();
    test_extreme_gains();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && demand_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
